FILE: sv/kuf_pkg.sv
// Shared widths and stream word layout for the union-find edge filter.
`default_nettype none

package kuf_pkg;

  localparam int NODE_W     = 10;
  localparam int WEIGHT_W   = 30;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;

  localparam int IN_A_LO   = 0;
  localparam int IN_B_LO   = IN_A_LO + NODE_W;
  localparam int IN_W_LO   = IN_B_LO + NODE_W;
  localparam int IN_USED_W = IN_W_LO + WEIGHT_W;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   node_b;
    logic [NODE_W-1:0]   node_a;
  } edge_t;

  typedef struct packed {
    logic [NODE_W-1:0]   set_root;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [NODE_W-1:0]   end_b;
    logic [NODE_W-1:0]   end_a;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/kuf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kuf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/kruskal_union_find_edge_filter_top.sv
// Top level of the union-find edge filter: parent table walker and result register.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+--------------------------------------
//  edge in | in  | s_tvalid/s_tready  | s_tdata: node_a, node_b, weight
//  result  | out | m_tvalid/m_tready  | m_tdata: end_a, end_b, edge_weight,
//          |     |                    |   set_root; m_tuser: accepted
//
//  One edge at a time. The parent table RAM read port is walked one hop
//  per cycle: each endpoint is walked once to find its root and once to
//  compress. Reset starts a clearing pass that writes the identity table;
//  s_tready stays low until it ends. A stalled result holds in the output
//  register while the next edge is accepted and walked.
`default_nettype none

module kruskal_union_find_edge_filter_top #(
  parameter int NODES = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // node_a[9:0], node_b[19:10], weight[49:20], zero pad
  input  wire logic [kuf_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // end_a[9:0], end_b[19:10], edge_weight[49:20], set_root[59:50], zero pad
  output logic      [kuf_pkg::OUT_DATA_W-1:0]   m_tdata,
  // accepted[0]
  output logic                                  m_tuser
);

  localparam int IW = $clog2(NODES);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FIND,
    S_COMP,
    S_LINK
  } state_t;

  state_t             state;
  logic [IW-1:0]      clr_cnt;
  logic [IW-1:0]      cur;
  logic [IW-1:0]      walk;
  logic [IW-1:0]      top;
  logic [IW-1:0]      root_a;
  logic               phase;
  logic               bad;
  kuf_pkg::edge_t     edge_q;
  kuf_pkg::edge_t     edge_in;
  kuf_pkg::result_t   res;
  logic               res_acc;

  logic               we;
  logic [IW-1:0]      waddr;
  logic [IW-1:0]      wdata;
  logic [IW-1:0]      raddr;
  logic [IW-1:0]      ram_q;
  logic               fwd_hit;
  logic [IW-1:0]      fwd_data;
  logic [IW-1:0]      q;

  logic [IW-1:0]      a_idx;
  logic [IW-1:0]      b_idx;
  logic [IW-1:0]      in_a_idx;
  logic [IW-1:0]      in_b_idx;
  logic [IW-1:0]      start;
  logic               in_bad;
  logic               out_free;
  logic               s_acc;
  logic               walk_end;
  logic [IW-1:0]      lo_root;
  logic [IW-1:0]      hi_root;

  assign edge_in  = kuf_pkg::edge_t'(s_tdata[kuf_pkg::IN_USED_W-1:0]);
  assign in_a_idx = IW'(edge_in.node_a);
  assign in_b_idx = IW'(edge_in.node_b);
  assign in_bad   = !((32'(edge_in.node_a) < NODES) && (32'(edge_in.node_b) < NODES));
  assign a_idx    = IW'(edge_q.node_a);
  assign b_idx    = IW'(edge_q.node_b);
  assign start    = phase ? b_idx : a_idx;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign q        = fwd_hit ? fwd_data : ram_q;
  assign walk_end = (q == walk) || (walk == top);
  assign lo_root  = (root_a < top) ? root_a : top;
  assign hi_root  = (root_a < top) ? top : root_a;

  always_comb begin
    we    = 1'b0;
    waddr = walk;
    wdata = top;
    raddr = cur;
    case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = clr_cnt;
      end
      S_IDLE: begin
        raddr = in_a_idx;
      end
      S_FIND: begin
        raddr = (q == cur) ? start : q;
      end
      S_COMP: begin
        we    = 1'b1;
        raddr = walk_end ? b_idx : q;
      end
      S_LINK: begin
        we    = !bad && (root_a != top);
        waddr = hi_root;
        wdata = lo_root;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  kuf_ram #(
    .WIDTH (IW),
    .DEPTH (NODES)
  ) u_parent (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    fwd_hit  <= we && (waddr == raddr);
    fwd_data <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
      bad      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_LINK)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IW'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_acc) begin
            edge_q <= edge_in;
            cur    <= in_a_idx;
            phase  <= 1'b0;
            bad    <= in_bad;
            state  <= in_bad ? S_LINK : S_FIND;
          end
        end
        S_FIND: begin
          if (q == cur) begin
            top   <= cur;
            walk  <= start;
            state <= S_COMP;
          end else begin
            cur <= q;
          end
        end
        S_COMP: begin
          if (walk_end) begin
            if (!phase) begin
              root_a <= top;
              phase  <= 1'b1;
              cur    <= b_idx;
              state  <= S_FIND;
            end else begin
              state <= S_LINK;
            end
          end else begin
            walk <= q;
          end
        end
        S_LINK: begin
          if (out_free) begin
            m_tvalid        <= 1'b1;
            res.end_a       <= edge_q.node_a;
            res.end_b       <= edge_q.node_b;
            res.edge_weight <= edge_q.weight;
            res.set_root    <= bad ? '0 : kuf_pkg::NODE_W'(lo_root);
            res_acc         <= !bad && (root_a != top);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(kuf_pkg::OUT_DATA_W - $bits(kuf_pkg::result_t)){1'b0}}, res};
  assign m_tuser = res_acc;

endmodule

`default_nettype wire

FILE: tb/kruskal_union_find_edge_filter_top_tb.sv
// Self-checking testbench for the union-find edge filter: directed edges, then random graph traffic.
module kruskal_union_find_edge_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES       = 1024;
  localparam int RANDOM_EDGES = 800;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_WAIT  = 200;
  localparam int N_PLAN      = 20;

  typedef struct packed {
    logic                         accepted;
    kuf_pkg::result_t             data;
  } verdict_t;

  typedef struct packed {
    logic [kuf_pkg::NODE_W-1:0]   a;
    logic [kuf_pkg::NODE_W-1:0]   b;
    logic [kuf_pkg::WEIGHT_W-1:0] w;
    logic                         fixed;
    logic                         acc;
    logic [kuf_pkg::NODE_W-1:0]   root;
  } plan_row_t;

  plan_row_t edge_plan [0:N_PLAN-1] = '{
    '{10'd0,    10'd1023, 30'd0,          1'b1, 1'b1, 10'd0},
    '{10'd1023, 10'd0,    30'h3FFFFFFF,   1'b1, 1'b0, 10'd0},
    '{10'd5,    10'd5,    30'h2AAAAAAA,   1'b1, 1'b0, 10'd5},
    '{10'd1022, 10'd1021, 30'h15555555,   1'b1, 1'b1, 10'd1021},
    '{10'd1023, 10'd1022, 30'd1,          1'b1, 1'b1, 10'd0},
    '{10'd1022, 10'd0,    30'h3FFFFFFE,   1'b1, 1'b0, 10'd0},
    '{10'd9,    10'd10,   30'h00000100,   1'b0, 1'b0, 10'd0},
    '{10'd8,    10'd9,    30'h00000200,   1'b0, 1'b0, 10'd0},
    '{10'd7,    10'd8,    30'h00000300,   1'b0, 1'b0, 10'd0},
    '{10'd6,    10'd7,    30'h00000400,   1'b0, 1'b0, 10'd0},
    '{10'd10,   10'd6,    30'h00000500,   1'b0, 1'b0, 10'd0},
    '{10'd10,   10'd5,    30'h20000000,   1'b0, 1'b0, 10'd0},
    '{10'd5,    10'd10,   30'h10000000,   1'b0, 1'b0, 10'd0},
    '{10'd512,  10'd511,  30'h0000FFFF,   1'b0, 1'b0, 10'd0},
    '{10'd682,  10'd341,  30'h2AAAAAAA,   1'b0, 1'b0, 10'd0},
    '{10'd341,  10'd682,  30'h15555555,   1'b0, 1'b0, 10'd0},
    '{10'd1023, 10'd682,  30'h3FFF0000,   1'b0, 1'b0, 10'd0},
    '{10'd1021, 10'd1021, 30'h00003FFF,   1'b0, 1'b0, 10'd0},
    '{10'd3,    10'd1,    30'h12345678,   1'b0, 1'b0, 10'd0},
    '{10'd1,    10'd3,    30'h0ABCDEF0,   1'b0, 1'b0, 10'd0}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [kuf_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [kuf_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tuser;

  logic [kuf_pkg::NODE_W-1:0] forest_parent [0:NODES-1];
  verdict_t          pending_verdicts [$];
  int                mismatches = 0;
  int                edges_sent = 0;
  int                cycle_count = 0;
  int                burst_left = 0;

  int                rx_phase = 0;
  int                rx_hold = 0;
  bit                rx_pressed = 1'b0;
  logic [15:0]       rx_pattern = '1;

  kruskal_union_find_edge_filter_top #(.NODES(NODES)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [kuf_pkg::NODE_W-1:0] find_and_flatten(
    input logic [kuf_pkg::NODE_W-1:0] node);
    logic [kuf_pkg::NODE_W-1:0] top;
    logic [kuf_pkg::NODE_W-1:0] walk;
    logic [kuf_pkg::NODE_W-1:0] up;
    top = node;
    for (int g = 0; g < NODES; g++) begin
      up = forest_parent[top];
      if (up == top) break;
      top = up;
    end
    walk = node;
    for (int g = 0; g < NODES; g++) begin
      up = forest_parent[walk];
      forest_parent[walk] = top;
      if (up == walk || walk == top) break;
      walk = up;
    end
    return top;
  endfunction

  function automatic verdict_t predict_edge(input kuf_pkg::edge_t e);
    verdict_t v;
    logic [kuf_pkg::NODE_W-1:0] ra;
    logic [kuf_pkg::NODE_W-1:0] rb;
    v = '0;
    v.data.end_a       = e.node_a;
    v.data.end_b       = e.node_b;
    v.data.edge_weight = e.weight;
    if (int'(e.node_a) < NODES && int'(e.node_b) < NODES) begin
      ra = find_and_flatten(e.node_a);
      rb = find_and_flatten(e.node_b);
      if (ra == rb) begin
        v.data.set_root = ra;
      end else if (ra < rb) begin
        forest_parent[rb] = ra;
        v.data.set_root = ra;
        v.accepted = 1'b1;
      end else begin
        forest_parent[ra] = rb;
        v.data.set_root = rb;
        v.accepted = 1'b1;
      end
    end
    return v;
  endfunction

  // offer one edge word, hold it until taken, then record what must come back
  task automatic offer_edge(input kuf_pkg::edge_t e, input bit fixed, input bit acc,
                            input logic [kuf_pkg::NODE_W-1:0] root);
    verdict_t v;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(kuf_pkg::IN_DATA_W-kuf_pkg::IN_USED_W){1'b0}}, e};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    v = predict_edge(e);
    if (fixed) begin
      v.accepted      = acc;
      v.data.set_root = root;
    end
    pending_verdicts.insert(pending_verdicts.size(), v);
    edges_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                              : $urandom_range(0, 15);
    end
  endtask

  function automatic kuf_pkg::edge_t make_edge(input int a, input int b);
    kuf_pkg::edge_t e;
    e.node_a = kuf_pkg::NODE_W'(a);
    e.node_b = kuf_pkg::NODE_W'(b);
    e.weight = kuf_pkg::WEIGHT_W'($urandom);
    return e;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    kuf_pkg::edge_t e;
    int    pick;
    int    base;
    int    len;
    for (int i = 0; i < NODES; i++) forest_parent[i] = kuf_pkg::NODE_W'(i);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_PLAN; i++) begin
      e.node_a = edge_plan[i].a;
      e.node_b = edge_plan[i].b;
      e.weight = edge_plan[i].w;
      offer_edge(e, edge_plan[i].fixed, edge_plan[i].acc, edge_plan[i].root);
    end

    while (edges_sent < N_PLAN + RANDOM_EDGES) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        // build a descending chain, then close it from the far end
        len  = $urandom_range(2, 24);
        base = $urandom_range(0, NODES - 2 - len);
        for (int k = len - 1; k >= 0; k--) offer_edge(make_edge(base + k, base + k + 1), 0, 0, 0);
        offer_edge(make_edge(base + len, base + $urandom_range(0, len - 1)), 0, 0, 0);
      end else if (pick < 7) begin
        base = $urandom_range(0, NODES - 64);
        offer_edge(make_edge(base + $urandom_range(0, 63), base + $urandom_range(0, 63)), 0, 0, 0);
      end else if (pick < 9) begin
        offer_edge(make_edge($urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1)), 0, 0, 0);
      end else begin
        case ($urandom_range(0, 2))
          0: base = 0;
          1: base = NODES - 1;
          default: base = $urandom_range(0, NODES - 1);
        endcase
        offer_edge(make_edge(base, ($urandom_range(0, 1) == 1) ? base : NODES - 1 - base),
                   0, 0, 0);
      end
    end
    s_tvalid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // receiver: rotating stall pattern, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!rx_pressed && edges_sent >= 300) begin
        rx_pressed = 1'b1;
        rx_hold    = 400;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        if (rx_phase == 0) begin
          rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
        end
        m_tready <= rx_pattern[rx_phase % 16];
        rx_phase  = (rx_phase + 1) % 64;
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t         want;
    kuf_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(kuf_pkg::result_t)-1:0];
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result word expected none, actual %h", $realtime, m_tdata);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("accepted",    want.accepted,         m_tuser);
        check_field("end_a",       want.data.end_a,       got.end_a);
        check_field("end_b",       want.data.end_b,       got.end_b);
        check_field("edge_weight", want.data.edge_weight, got.edge_weight);
        check_field("set_root",    want.data.set_root,    got.set_root);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $realtime, pending_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
